[hw/rtl/ede_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and codes of the edit distance engine
package ede_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int COST_W  = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 8;
  localparam int DIST_W  = 7;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_FIRST  = 2'd1,
    REQ_SECOND = 2'd2,
    REQ_END    = 2'd3
  } req_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_t;

  // token that ripples down the cell chain, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] new_cost;
    logic [COST_W-1:0] old_cost;
    logic [CHAR_W-1:0] ch;
  } token_t;

  // shared control bus from the sequencer to every cell
  typedef struct packed {
    logic              clear;
    logic [CHAR_W-1:0] wr_char;
    logic [COST_W-1:0] wr_cost;
  } cell_ctl_t;

endpackage

[hw/rtl/ede_cell.sv]
`timescale 1ns / 1ps
// one column cell: holds one first-string char and its row cost
module ede_cell (
  input  logic              clk,
  input  logic              rst,
  input  ede_pkg::cell_ctl_t ctl,
  input  logic              wr_en,
  input  ede_pkg::token_t   tok_in,
  output ede_pkg::token_t   tok_out
);

  logic                               used;
  logic [ede_pkg::CHAR_W-1:0]         ch;
  logic [ede_pkg::COST_W-1:0]         cost;
  logic                               out_valid;
  logic [ede_pkg::COST_W-1:0]         out_new;
  logic [ede_pkg::COST_W-1:0]         out_old;
  logic [ede_pkg::CHAR_W-1:0]         out_ch;

  logic [ede_pkg::COST_W:0]           up1;
  logic [ede_pkg::COST_W:0]           left1;
  logic [ede_pkg::COST_W:0]           sub;
  logic [ede_pkg::COST_W:0]           m01;
  logic [ede_pkg::COST_W:0]           best;
  logic [ede_pkg::COST_W-1:0]         cost_next;

  always_comb begin
    up1   = {1'b0, cost} + 1'b1;
    left1 = {1'b0, tok_in.new_cost} + 1'b1;
    sub   = {1'b0, tok_in.old_cost} + {{ede_pkg::COST_W{1'b0}}, (ch != tok_in.ch)};
    m01   = (up1 < left1) ? up1 : left1;
    best  = (m01 < sub) ? m01 : sub;
    cost_next = best[ede_pkg::COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= tok_in.valid;
      if (ctl.clear) begin
        used <= 1'b0;
      end else if (wr_en) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ch   <= ctl.wr_char;
      cost <= ctl.wr_cost;
    end else if (tok_in.valid && used) begin
      cost <= cost_next;
    end
    // unused cells pass the left value through so the chain end sees the tail
    out_new <= used ? cost_next : tok_in.new_cost;
    out_old <= cost;
    out_ch  <= tok_in.ch;
  end

  assign tok_out = '{valid: out_valid, new_cost: out_new, old_cost: out_old, ch: out_ch};

endmodule

[hw/rtl/edit_distance_engine_core.sv]
`timescale 1ns / 1ps
// top level of the edit distance engine: sequencer, column zero and cell chain
//
//  channel | handshake           | word
//  --------+---------------------+----------------------------------
//  in      | in_valid / in_ready | req_type, symbol
//  out     | out_valid/out_ready | edit_distance, length_overflow
//
// start, first-string and end words are taken without a sweep
// a second-string word starts a sweep: a token ripples through all
//   MAX_LEN cells, one cell per cycle, and the chain end returns the tail cost
// in_ready is low during a sweep and while an unread result sits in the output
// register; the output register frees the input side once the result is taken
// synchronous reset clears lengths, flags, column zero and all cell used bits
module edit_distance_engine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 req_type,
  input  logic [ede_pkg::CHAR_W-1:0] symbol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ede_pkg::DIST_W-1:0] edit_distance,
  output logic                       length_overflow
);

  ede_pkg::state_t                 state;
  ede_pkg::state_t                 state_next;
  logic [ede_pkg::LEN_W-1:0]       first_length;
  logic [ede_pkg::LEN_W-1:0]       second_length;
  logic                            overflow_seen;
  logic [ede_pkg::COST_W-1:0]      cost0;     // row column zero
  logic [ede_pkg::COST_W-1:0]      tail;      // cost_row[first_length]
  logic                            tok0_valid;
  logic [ede_pkg::COST_W-1:0]      tok0_new;
  logic [ede_pkg::COST_W-1:0]      tok0_old;
  logic [ede_pkg::CHAR_W-1:0]      tok0_ch;

  ede_pkg::req_t                   req;
  logic                            accept;
  logic                            first_full;
  logic                            second_full;
  logic                            do_first;
  logic                            do_second;
  logic                            sweep_done;
  ede_pkg::cell_ctl_t              ctl;
  ede_pkg::token_t                 tok [0:ede_pkg::MAX_LEN];
  logic [ede_pkg::MAX_LEN-1:0]     wr_en;

  assign req         = ede_pkg::req_t'(req_type);
  assign accept      = in_valid && in_ready;
  assign first_full  = (first_length == ede_pkg::LEN_W'(ede_pkg::MAX_LEN));
  assign second_full = (second_length == ede_pkg::LEN_W'(ede_pkg::MAX_LEN));
  // first-string chars are dropped once any second-string char has swept
  assign do_first    = accept && (req == ede_pkg::REQ_FIRST) &&
                       (second_length == '0) && !first_full;
  assign do_second   = accept && (req == ede_pkg::REQ_SECOND) && !second_full;
  assign sweep_done  = tok[ede_pkg::MAX_LEN].valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ede_pkg::ST_IDLE: begin
        if (do_second) begin
          state_next = ede_pkg::ST_SWEEP;
        end
      end
      ede_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          state_next = ede_pkg::ST_IDLE;
        end
      end
      default: state_next = ede_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    case (state)
      ede_pkg::ST_IDLE:  in_ready = !out_valid || out_ready;
      ede_pkg::ST_SWEEP: in_ready = 1'b0;
      default:           in_ready = 1'b0;
    endcase
  end

  // broadcast bus to the cells
  assign ctl = '{clear:   accept && (req == ede_pkg::REQ_START),
                 wr_char: symbol,
                 wr_cost: ede_pkg::COST_W'({1'b0, first_length} + 1'b1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ede_pkg::ST_IDLE;
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      cost0         <= '0;
      tail          <= '0;
      tok0_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      tok0_valid <= do_second;
      if (sweep_done) begin
        tail <= tok[ede_pkg::MAX_LEN].new_cost;
      end
      if (accept) begin
        case (req)
          ede_pkg::REQ_START: begin
            first_length  <= '0;
            second_length <= '0;
            overflow_seen <= 1'b0;
            cost0         <= '0;
            tail          <= '0;
          end
          ede_pkg::REQ_FIRST: begin
            if (do_first) begin
              first_length <= first_length + 1'b1;
              tail         <= ctl.wr_cost;
            end else if (second_length == '0) begin
              overflow_seen <= 1'b1;
            end
          end
          ede_pkg::REQ_SECOND: begin
            if (do_second) begin
              second_length <= second_length + 1'b1;
              cost0         <= ede_pkg::COST_W'({1'b0, second_length} + 1'b1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (accept && (req == ede_pkg::REQ_END)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: injected token and result word
  always_ff @(posedge clk) begin
    if (do_second) begin
      tok0_new <= ede_pkg::COST_W'({1'b0, second_length} + 1'b1);
      tok0_old <= cost0;
      tok0_ch  <= symbol;
    end
    if (accept && (req == ede_pkg::REQ_END)) begin
      edit_distance   <= ede_pkg::DIST_W'(tail);
      length_overflow <= overflow_seen;
    end
  end

  assign tok[0] = '{valid: tok0_valid, new_cost: tok0_new, old_cost: tok0_old, ch: tok0_ch};

  // cell k holds first-string char k and cost_row[k+1]
  for (genvar i = 0; i < ede_pkg::MAX_LEN; i++) begin : g_cell
    assign wr_en[i] = do_first && (first_length == ede_pkg::LEN_W'(i));
    ede_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .wr_en   (wr_en[i]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // no new word while a token is still in the chain
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ede_pkg::ST_SWEEP) |-> !in_ready)
    else $error("input accepted during sweep");

  // an accepted second-string char launches a token in the next cycle
  a_token_launch: assert property (@(posedge clk) disable iff (rst)
    do_second |=> (tok0_valid && (state == ede_pkg::ST_SWEEP)))
    else $error("sweep token not launched");

  // the chain end only reports while the sequencer waits for it
  a_done_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep_done |-> (state == ede_pkg::ST_SWEEP))
    else $error("stray token at chain end");

  // lengths never pass the cell count
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (first_length <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) &&
    (second_length <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)))
    else $error("string length out of range");

  // a distance word never exceeds MAX_LEN
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edit_distance <= ede_pkg::DIST_W'(ede_pkg::MAX_LEN)))
    else $error("distance out of range");

endmodule

[tb/sv/edit_distance_engine_core_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the edit distance engine with a cycle-free distance predictor
module edit_distance_engine_core_tb;
  import ede_pkg::*;

  // one word on the input channel
  typedef struct {
    req_t             kind;
    logic [CHAR_W-1:0] ch;
  } edit_word_t;

  // one word on the output channel
  typedef struct {
    logic [DIST_W-1:0] cost;
    logic              ovf;
  } distance_t;

  localparam int WORD_TARGET = 650;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        req_type = REQ_START;
  logic [CHAR_W-1:0] symbol = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DIST_W-1:0] edit_distance;
  logic              length_overflow;

  edit_distance_engine_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .symbol          (symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .edit_distance   (edit_distance),
    .length_overflow (length_overflow)
  );

  always #2 clk = ~clk;

  // words waiting to be driven and distances waiting to come out
  edit_word_t pending_words[$];
  distance_t  expected_distances[$];
  int         words_queued = 0;
  int         mismatches = 0;

  // predictor copy of the engine state
  logic [CHAR_W-1:0] first_str[MAX_LEN];
  int                first_cnt = 0;
  int                second_cnt = 0;
  int                dp_row[MAX_LEN + 1];
  bit                trunc_seen = 1'b0;

  // handshake bookkeeping between the clocked blocks
  logic word_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   calm_left = 0;

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // advance the predicted state by one accepted word, queueing any distance it emits
  function automatic void advance_distance(req_t kind, logic [CHAR_W-1:0] ch);
    int        diag;
    int        up;
    int        sub;
    int        best;
    distance_t res;
    case (kind)
      REQ_START: begin
        first_cnt  = 0;
        second_cnt = 0;
        trunc_seen = 1'b0;
        dp_row[0]  = 0;
      end
      REQ_FIRST: begin
        // row already swept: late first-string chars are dropped silently
        if (second_cnt == 0) begin
          if (first_cnt >= MAX_LEN) begin
            trunc_seen = 1'b1;
          end else begin
            first_str[first_cnt] = ch;
            first_cnt++;
            dp_row[first_cnt] = first_cnt;
          end
        end
      end
      REQ_SECOND: begin
        if (second_cnt >= MAX_LEN) begin
          trunc_seen = 1'b1;
        end else begin
          // one sweep of the stored row against the new char
          diag = dp_row[0];
          dp_row[0] = second_cnt + 1;
          for (int i = 1; i <= first_cnt; i++) begin
            up   = dp_row[i];
            sub  = diag + ((first_str[i-1] != ch) ? 1 : 0);
            best = up + 1;
            if (dp_row[i-1] + 1 < best) best = dp_row[i-1] + 1;
            if (sub < best) best = sub;
            dp_row[i] = best;
            diag = up;
          end
          second_cnt++;
        end
      end
      default: begin
        res.cost = dp_row[first_cnt][DIST_W-1:0];
        res.ovf  = trunc_seen;
        expected_distances = {expected_distances, res};
      end
    endcase
  endfunction

  function automatic void push_word(req_t kind, logic [CHAR_W-1:0] ch);
    edit_word_t w;
    w.kind = kind;
    w.ch   = ch;
    pending_words = {pending_words, w};
    words_queued++;
  endfunction

  // a small alphabet makes matches common, the full byte range covers every bit
  function automatic logic [CHAR_W-1:0] pick_char(bit narrow);
    if (narrow) return CHAR_W'(8'h61 + $urandom_range(0, 3));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(0, 8);
    if (r < 96) return $urandom_range(9, 40);
    return $urandom_range(60, 68);
  endfunction

  // one pair of strings, mostly well formed, sometimes broken or pure noise
  function automatic void queue_pair();
    int r;
    int n1;
    int n2;
    bit narrow;
    bit no_start;
    bit late_first;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: random request kinds with random bytes
      repeat ($urandom_range(1, 6))
        push_word(req_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
      return;
    end
    narrow     = ($urandom_range(0, 9) < 7);
    no_start   = (r < 11);
    late_first = (r >= 11 && r < 15);
    n1 = pick_len();
    n2 = pick_len();
    if (!no_start) push_word(REQ_START, CHAR_W'($urandom_range(0, 255)));
    for (int i = 0; i < n1; i++) push_word(REQ_FIRST, pick_char(narrow));
    for (int i = 0; i < n2; i++) begin
      push_word(REQ_SECOND, pick_char(narrow));
      if (late_first && $urandom_range(0, 2) == 0) push_word(REQ_FIRST, pick_char(narrow));
    end
    push_word(REQ_END, CHAR_W'($urandom_range(0, 255)));
    // repeated end now and then
    if ($urandom_range(0, 9) == 0) push_word(REQ_END, CHAR_W'($urandom_range(0, 255)));
  endfunction

  // input driver: new word or gap on the falling edge, hold until taken
  always @(negedge clk) begin
    edit_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_words.size() > 0) begin
      w = pending_words.pop_front();
      in_valid <= 1'b1;
      req_type <= w.kind;
      symbol   <= w.ch;
      send_gap <= (calm_left > 0) ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output back-pressure, with calm stretches where nothing stalls
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left  <= calm_left - 1;
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 299) == 0) calm_left <= 200;
      else if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // sample both channels on the rising edge
  always @(posedge clk) begin
    distance_t want;
    word_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_distances.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: dist %0d ovf %0b", edit_distance,
                     length_overflow);
        end else begin
          want = expected_distances.pop_front();
          if (edit_distance !== want.cost || length_overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result word mismatch: expected dist %0d ovf %0b, got dist %0d ovf %0b",
                       want.cost, want.ovf, edit_distance, length_overflow);
          end
        end
      end
      if (in_valid && in_ready) advance_distance(req_t'(req_type), symbol);
    end
  end

  // stimulus and end of run
  initial begin
    // end with no start and a repeated end
    push_word(REQ_END, 8'h00);
    push_word(REQ_END, 8'hFF);
    // both strings empty
    push_word(REQ_START, 8'hFF);
    push_word(REQ_END, 8'h00);
    // empty first string
    push_word(REQ_START, 8'h00);
    push_word(REQ_SECOND, 8'h00);
    push_word(REQ_SECOND, 8'hFF);
    push_word(REQ_END, 8'h55);
    // empty second string
    push_word(REQ_START, 8'hAA);
    push_word(REQ_FIRST, 8'hFF);
    push_word(REQ_FIRST, 8'h00);
    push_word(REQ_FIRST, 8'h55);
    push_word(REQ_END, 8'hAA);
    // first char arriving after the sweep is ignored, end repeated
    push_word(REQ_START, 8'h00);
    push_word(REQ_FIRST, 8'h61);
    push_word(REQ_FIRST, 8'h62);
    push_word(REQ_SECOND, 8'h61);
    push_word(REQ_SECOND, 8'h63);
    push_word(REQ_FIRST, 8'h7A);
    push_word(REQ_END, 8'h00);
    push_word(REQ_END, 8'hFF);
    // overflow on both sides is reached by the long random pairs
    while (words_queued < WORD_TARGET) queue_pair();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_distances.size() > 0) @(posedge clk);
    // drain: any stray result in this window is flagged by the monitor
    repeat (MAX_LEN + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ede_pkg.sv
hw/rtl/ede_cell.sv
hw/rtl/edit_distance_engine_core.sv
tb/sv/edit_distance_engine_core_tb.sv
